// ===== design/relative_strength_index_defines.svh =====
// Assertion macros for the relative strength index block.
// Included by the modules that carry assertions; assumes clk and rst in scope.
`ifndef RELATIVE_STRENGTH_INDEX_DEFINES_SVH
`define RELATIVE_STRENGTH_INDEX_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RSI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define RSI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rsi_pkg.sv =====
// Shared types and constants for the relative strength index block.
// No dependencies; used by rsi_div and relative_strength_index.
package rsi_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_MAX_DEF      = 64;
  localparam int RATIO_FRAC_BITS_DEF = 20;

  // Fixed field widths.
  localparam int PRICE_W = 32;
  localparam int CFG_W   = 7;
  localparam int RSI_W   = 15;

  // Change entry: sign bit on top of a saturated magnitude.
  localparam int CHANGE_W = 24;
  localparam int ENTRY_W  = CHANGE_W + 1;
  localparam logic [CHANGE_W-1:0] CHANGE_MAX = '1;

  // Q7.8 scale of 100, and window length after reset.
  localparam int SCALE_Q78    = 25600;
  localparam int WINDOW_RESET = 14;

  // Quotient bits of the shared divider and step counts of its two uses.
  localparam int QUOT_W      = CHANGE_W;
  localparam int STEP_W      = $clog2(QUOT_W + 1);
  localparam int CDIV_STEPS  = CHANGE_W;
  localparam int RDIV_STEPS  = RSI_W;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHANGE,
    ST_CDIV,
    ST_UPDATE,
    ST_SCALE,
    ST_RSTART,
    ST_RDIV,
    ST_FINISH
  } rsi_state_t;

  // Divider control and status.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/relative_strength_index.sv =====
// Relative strength index, simple average form, one result per price bar.
// A bar is taken only while the block is idle and occupies it through a 24-step
// division for the relative change and a 15-step division for the index, each
// skipped when not needed, on one shared radix-2 divider, plus sequencing, ring
// access and sum update. A finished result waits in the output register, so the
// next bar can be taken while it is still stalled. The change ring sits in a
// synchronous RAM that is read and written back once per bar; the two accesses
// of one bar never overlap with those of another. The ring needs no clearing
// pass: the fill count keeps any entry from being read before it is written.
// Depends on rsi_pkg, rsi_ram, rsi_div and relative_strength_index_defines.svh.
`include "relative_strength_index_defines.svh"

module relative_strength_index #(
  parameter int WINDOW_MAX      = rsi_pkg::WINDOW_MAX_DEF,
  parameter int RATIO_FRAC_BITS = rsi_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rsi_pkg::CFG_W-1:0]   cfg_data,
  // Input requests.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rsi_pkg::PRICE_W-1:0] open_price,
  input  logic [rsi_pkg::PRICE_W-1:0] close_price,
  input  logic                        restart,
  // Result requests.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rsi_pkg::RSI_W-1:0]   rsi_value,
  output logic                        ready_res,
  output logic                        undefined,
  output logic                        bad_open
);

  localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int LCMP_W  = (rsi_pkg::CFG_W > LEN_W) ? rsi_pkg::CFG_W : LEN_W;
  localparam int RESET_LEN = (rsi_pkg::WINDOW_RESET > WINDOW_MAX) ?
                             WINDOW_MAX : rsi_pkg::WINDOW_RESET;
  localparam int SUM_W   = rsi_pkg::CHANGE_W + $clog2(WINDOW_MAX);
  localparam int TOT_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + rsi_pkg::RSI_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int DV_W    = (rsi_pkg::PRICE_W > TOT_W) ? rsi_pkg::PRICE_W : TOT_W;
  localparam int DD_W    = rsi_pkg::PRICE_W + RATIO_FRAC_BITS;
  localparam int OV_W    = rsi_pkg::PRICE_W +
                           ((RATIO_FRAC_BITS > rsi_pkg::CHANGE_W) ?
                            RATIO_FRAC_BITS : rsi_pkg::CHANGE_W);
  localparam int PAD_W   = rsi_pkg::QUOT_W - rsi_pkg::RSI_W;
  localparam logic [rsi_pkg::RSI_W-1:0] RSI_MAX = rsi_pkg::RSI_W'(rsi_pkg::SCALE_Q78);

  rsi_pkg::rsi_state_t state, state_next;

  // Configuration and history.
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   cfg_len;
  logic [LCMP_W-1:0]  cfg_ext;
  logic [SUM_W-1:0]   gain_sum, loss_sum;
  logic [SUM_W-1:0]   gain_next, loss_next;
  logic [SLOT_W-1:0]  write_slot;
  logic [LEN_W-1:0]   fill_count;
  logic [SLOT_W-1:0]  slot_eff;

  // Per-bar working registers.
  logic [rsi_pkg::PRICE_W-1:0] open_q, diff_q;
  logic                        neg_q, bad_q, ovf_q, ready_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [TOT_W-1:0]            total_q;
  logic [PROD_W-1:0]           prod_q;
  logic [rsi_pkg::RSI_W-1:0]   rsi_q;
  logic                        undef_q;

  // Change and index arithmetic.
  logic [DD_W-1:0]             dividend;
  logic                        ovf_c;
  logic                        open_zero;
  logic [NUM_W-1:0]            num;
  logic [rsi_pkg::CHANGE_W-1:0] new_mag, old_mag;
  logic                        new_neg, old_neg;
  logic                        full;
  logic [LEN_W-1:0]            fill_after;
  logic [LEN_W-1:0]            slot_inc;

  // Divider and ring ports.
  rsi_pkg::div_ctrl_t          div_ctrl;
  rsi_pkg::div_stat_t          div_stat;
  logic [DV_W-1:0]             div_rem, div_dvs;
  logic [rsi_pkg::QUOT_W-1:0]  div_low, div_quot;
  logic                        ram_rd, ram_wr;
  logic [rsi_pkg::ENTRY_W-1:0] ram_rdata;

  logic in_acc, cfg_acc, out_free;

  assign in_stall  = (state != rsi_pkg::ST_IDLE);
  assign cfg_ready = (state == rsi_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  // Written window length clamped to one through the ring depth.
  always_comb begin
    cfg_ext = LCMP_W'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_ext > LCMP_W'(WINDOW_MAX)) begin
      cfg_len = LEN_W'(WINDOW_MAX);
    end else begin
      cfg_len = LEN_W'(cfg_ext);
    end
  end

  // Relative change: saturation test and divider operands.
  assign open_zero = (open_q == '0);
  assign dividend  = DD_W'(diff_q) << RATIO_FRAC_BITS;
  assign ovf_c     = (OV_W'(dividend) >= (OV_W'(open_q) << rsi_pkg::CHANGE_W));

  // Index numerator: scaled gain plus half the total for rounding.
  assign num = NUM_W'(prod_q) + NUM_W'(total_q >> 1);

  // Slot that this bar overwrites, wrapped to the window.
  always_comb begin
    if (LEN_W'(write_slot) >= eff_len) begin
      slot_eff = '0;
    end else begin
      slot_eff = write_slot;
    end
  end

  // New ring entry, the entry it replaces, and the updated sums.
  always_comb begin
    if (bad_q) begin
      new_mag = '0;
    end else if (ovf_q) begin
      new_mag = rsi_pkg::CHANGE_MAX;
    end else begin
      new_mag = div_quot;
    end
    new_neg    = neg_q && (new_mag != '0);
    old_mag    = ram_rdata[rsi_pkg::CHANGE_W-1:0];
    old_neg    = ram_rdata[rsi_pkg::CHANGE_W];
    full       = (fill_count >= eff_len);
    fill_after = full ? fill_count : fill_count + LEN_W'(1);
    slot_inc   = LEN_W'(slot_q) + LEN_W'(1);
    gain_next  = gain_sum;
    loss_next  = loss_sum;
    if (full && !old_neg) begin
      gain_next = gain_next - SUM_W'(old_mag);
    end
    if (full && old_neg) begin
      loss_next = loss_next - SUM_W'(old_mag);
    end
    if (new_neg) begin
      loss_next = loss_next + SUM_W'(new_mag);
    end else begin
      gain_next = gain_next + SUM_W'(new_mag);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      rsi_pkg::ST_IDLE: begin
        if (in_acc) state_next = rsi_pkg::ST_CHANGE;
      end
      rsi_pkg::ST_CHANGE: begin
        if (open_zero || ovf_c) begin
          state_next = rsi_pkg::ST_UPDATE;
        end else begin
          state_next = rsi_pkg::ST_CDIV;
        end
      end
      rsi_pkg::ST_CDIV: begin
        if (div_stat.done) state_next = rsi_pkg::ST_UPDATE;
      end
      rsi_pkg::ST_UPDATE: state_next = rsi_pkg::ST_SCALE;
      rsi_pkg::ST_SCALE:  state_next = rsi_pkg::ST_RSTART;
      rsi_pkg::ST_RSTART: begin
        if (!ready_q || total_q == '0) begin
          state_next = rsi_pkg::ST_FINISH;
        end else begin
          state_next = rsi_pkg::ST_RDIV;
        end
      end
      rsi_pkg::ST_RDIV: begin
        if (div_stat.done) state_next = rsi_pkg::ST_FINISH;
      end
      rsi_pkg::ST_FINISH: begin
        if (out_free) state_next = rsi_pkg::ST_IDLE;
      end
      default: state_next = rsi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider launch, operand select, ring accesses.
  always_comb begin
    div_ctrl = '0;
    div_rem  = '0;
    div_low  = '0;
    div_dvs  = '0;
    ram_rd   = 1'b0;
    ram_wr   = 1'b0;
    case (state)
      rsi_pkg::ST_CHANGE: begin
        ram_rd         = 1'b1;
        div_ctrl.start = !open_zero && !ovf_c;
        div_ctrl.steps = rsi_pkg::STEP_W'(rsi_pkg::CDIV_STEPS);
        div_rem        = DV_W'(dividend >> rsi_pkg::CHANGE_W);
        div_low        = dividend[rsi_pkg::CHANGE_W-1:0];
        div_dvs        = DV_W'(open_q);
      end
      rsi_pkg::ST_UPDATE: begin
        ram_wr = 1'b1;
      end
      rsi_pkg::ST_RSTART: begin
        div_ctrl.start = ready_q && (total_q != '0);
        div_ctrl.steps = rsi_pkg::STEP_W'(rsi_pkg::RDIV_STEPS);
        div_rem        = DV_W'(num >> rsi_pkg::RSI_W);
        div_low        = rsi_pkg::QUOT_W'(num[rsi_pkg::RSI_W-1:0]) << PAD_W;
        div_dvs        = DV_W'(total_q);
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window length and history; a write or a restart clears the history.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len    <= LEN_W'(RESET_LEN);
      gain_sum   <= '0;
      loss_sum   <= '0;
      write_slot <= '0;
      fill_count <= '0;
    end else if (cfg_acc) begin
      eff_len    <= cfg_len;
      gain_sum   <= '0;
      loss_sum   <= '0;
      write_slot <= '0;
      fill_count <= '0;
    end else if (in_acc && restart) begin
      gain_sum   <= '0;
      loss_sum   <= '0;
      write_slot <= '0;
      fill_count <= '0;
    end else if (state == rsi_pkg::ST_UPDATE) begin
      gain_sum   <= gain_next;
      loss_sum   <= loss_next;
      fill_count <= fill_after;
      if (slot_inc >= eff_len) begin
        write_slot <= '0;
      end else begin
        write_slot <= SLOT_W'(slot_inc);
      end
    end
  end

  // Per-bar working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      open_q    <= open_price;
      neg_q     <= (close_price < open_price);
      if (close_price < open_price) begin
        diff_q <= open_price - close_price;
      end else begin
        diff_q <= close_price - open_price;
      end
    end
    if (state == rsi_pkg::ST_CHANGE) begin
      bad_q  <= open_zero;
      ovf_q  <= ovf_c;
      slot_q <= slot_eff;
    end
    if (state == rsi_pkg::ST_UPDATE) begin
      ready_q <= (fill_after >= eff_len);
    end
    if (state == rsi_pkg::ST_SCALE) begin
      total_q <= TOT_W'(gain_sum) + TOT_W'(loss_sum);
      prod_q  <= PROD_W'(gain_sum) * PROD_W'(rsi_pkg::SCALE_Q78);
    end
    if (state == rsi_pkg::ST_RSTART) begin
      rsi_q   <= '0;
      undef_q <= ready_q && (total_q == '0);
    end
    if (state == rsi_pkg::ST_RDIV && div_stat.done) begin
      rsi_q <= div_quot[rsi_pkg::RSI_W-1:0];
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rsi_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rsi_pkg::ST_FINISH && out_free) begin
      rsi_value <= rsi_q;
      ready_res <= ready_q;
      undefined <= undef_q;
      bad_open  <= bad_q;
    end
  end

  // Change ring.
  rsi_ram #(
    .WIDTH (rsi_pkg::ENTRY_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (slot_q),
    .wr_data ({new_neg, new_mag}),
    .rd_en   (ram_rd),
    .rd_addr (slot_eff),
    .rd_data (ram_rdata)
  );

  // Shared divider.
  rsi_div #(
    .DV_W (DV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .rem_init (div_rem),
    .low_bits (div_low),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  `RSI_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "input not stalled after accept")
  `RSI_ASSERT_ALWAYS(a_fill_bound, fill_count <= eff_len, "fill count exceeds window length")
  `RSI_ASSERT_ALWAYS(a_slot_bound, LEN_W'(write_slot) < eff_len, "write slot outside window")
  `RSI_ASSERT_SAME(a_empty_sums, fill_count == '0, (gain_sum | loss_sum) == '0, "sums not empty")
  `RSI_ASSERT_SAME(a_rsi_range, out_valid, rsi_value <= RSI_MAX, "index above 100")

endmodule

// ===== design/rsi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rsi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on rsi_pkg for the control and status structs.
module rsi_div #(
  parameter int DV_W = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rsi_pkg::div_ctrl_t           ctrl,
  input  logic [DV_W-1:0]              rem_init,
  input  logic [rsi_pkg::QUOT_W-1:0]   low_bits,
  input  logic [DV_W-1:0]              divisor,
  output rsi_pkg::div_stat_t           stat,
  output logic [rsi_pkg::QUOT_W-1:0]   quotient
);

  logic [DV_W-1:0]                rem;
  logic [DV_W-1:0]                rem_next;
  logic [DV_W-1:0]                dvs;
  logic [rsi_pkg::QUOT_W-1:0]     low;
  logic [rsi_pkg::STEP_W-1:0]     cnt;
  logic [DV_W:0]                  trial;
  logic                           qbit;

  // One step: bring down the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem, low[rsi_pkg::QUOT_W-1]};
    qbit  = (trial >= {1'b0, dvs});
    if (qbit) begin
      rem_next = DV_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = DV_W'(trial);
    end
  end

  // Control: start loads the operands, then count down the steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (ctrl.start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && cnt == rsi_pkg::STEP_W'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= rem_init;
      low      <= low_bits;
      dvs      <= divisor;
      cnt      <= ctrl.steps;
      quotient <= '0;
    end else if (stat.busy) begin
      rem      <= rem_next;
      low      <= low << 1;
      cnt      <= cnt - rsi_pkg::STEP_W'(1);
      quotient <= {quotient[rsi_pkg::QUOT_W-2:0], qbit};
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for relative_strength_index: directed price bars, then random phases
// under several window lengths, each result checked against a typed value or a predictor kept in step here.
// Depends on rsi_pkg and the relative_strength_index RTL.

module tb;

  // One result request, field by field.
  typedef struct packed {
    logic [rsi_pkg::RSI_W-1:0] rsi;
    logic                      rdy;
    logic                      undef;
    logic                      bad;
  } rsi_result_t;

  // One row of the directed table: optional window write, the bar, optional typed result.
  typedef struct packed {
    logic                          cfg_en;
    logic [rsi_pkg::CFG_W-1:0]     cfg_val;
    logic [rsi_pkg::PRICE_W-1:0]   op;
    logic [rsi_pkg::PRICE_W-1:0]   cp;
    logic                          rs;
    logic                          fix_en;
    rsi_result_t                   fix;
  } bar_row_t;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE_CYC  = 60;
  localparam int NUM_ROWS    = 23;
  localparam int NUM_PHASES  = 8;

  localparam rsi_result_t WARMUP     = '{15'd0, 1'b0, 1'b0, 1'b0};
  localparam rsi_result_t WARMUP_BAD = '{15'd0, 1'b0, 1'b0, 1'b1};
  localparam rsi_result_t FLAT       = '{15'd0, 1'b1, 1'b1, 1'b0};
  localparam rsi_result_t FLAT_BAD   = '{15'd0, 1'b1, 1'b1, 1'b1};
  localparam rsi_result_t ALL_GAIN   = '{15'd25600, 1'b1, 1'b0, 1'b0};
  localparam rsi_result_t ALL_LOSS   = '{15'd0, 1'b1, 1'b0, 1'b0};
  localparam rsi_result_t NO_FIX     = '0;

  // Directed bars: extremes at the reset window, then window 1 and window 2.
  localparam bar_row_t DIRECTED [NUM_ROWS] = '{
    '{1'b0, 7'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, WARMUP_BAD},
    '{1'b0, 7'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, WARMUP_BAD},
    '{1'b0, 7'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'd1000,      32'd1001,      1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'd1000,      32'd999,       1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'd12345,     32'd67890,     1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'd100,       32'd50,        1'b0, 1'b0, NO_FIX},
    '{1'b0, 7'd0, 32'd100,       32'd150,       1'b1, 1'b1, WARMUP},
    '{1'b1, 7'd1, 32'd500,       32'd500,       1'b0, 1'b1, FLAT},
    '{1'b0, 7'd0, 32'd0,         32'd7,         1'b0, 1'b1, FLAT_BAD},
    '{1'b0, 7'd0, 32'd10,        32'd20,        1'b0, 1'b1, ALL_GAIN},
    '{1'b0, 7'd0, 32'd20,        32'd10,        1'b0, 1'b1, ALL_LOSS},
    '{1'b0, 7'd0, 32'd3,         32'd4,         1'b1, 1'b1, ALL_GAIN},
    '{1'b1, 7'd2, 32'd100,       32'd110,       1'b0, 1'b1, WARMUP},
    '{1'b0, 7'd0, 32'd100,       32'd90,        1'b0, 1'b0, NO_FIX},
    '{1'b0, 7'd0, 32'd100,       32'd95,        1'b0, 1'b0, NO_FIX}
  };

  // Random phases: window written, then this many bars. Negative window means draw one.
  localparam int PHASE_WIN [NUM_PHASES] = '{64, 0, 127, 2, 3, 14, -1, -1};
  localparam int PHASE_LEN [NUM_PHASES] = '{140, 40, 90, 50, 50, 60, 60, 60};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [rsi_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [rsi_pkg::PRICE_W-1:0]  open_price = '0;
  logic [rsi_pkg::PRICE_W-1:0]  close_price = '0;
  logic                         restart = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b1;
  logic [rsi_pkg::RSI_W-1:0]    rsi_value;
  logic                         ready_res;
  logic                         undefined;
  logic                         bad_open;

  // Typed result that travels with the bar currently offered.
  logic                fix_en_cur = 1'b0;
  rsi_result_t         fix_cur = '0;

  // Predictor state.
  logic [rsi_pkg::ENTRY_W-1:0] change_hist [rsi_pkg::WINDOW_MAX_DEF];
  longint unsigned             gain_total = 0;
  longint unsigned             loss_total = 0;
  int unsigned                 next_slot = 0;
  int unsigned                 bars_held = 0;
  logic [rsi_pkg::CFG_W-1:0]   window_reg = rsi_pkg::CFG_W'(rsi_pkg::WINDOW_RESET);

  rsi_result_t         index_expect_q [$];
  int                  errors = 0;
  int                  bars_in = 0;
  int                  results_out = 0;
  int                  undef_seen = 0;
  int                  bad_seen = 0;
  int                  window_writes = 0;
  int                  idle_cycles = 0;
  bit                  send_burst = 1'b0;
  bit                  recv_burst = 1'b0;

  relative_strength_index dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .open_price (open_price),
    .close_price(close_price),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rsi_value  (rsi_value),
    .ready_res  (ready_res),
    .undefined  (undefined),
    .bad_open   (bad_open)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A restart or a window write empties the gain and loss window.
  function automatic void clear_window_history();
    foreach (change_hist[i]) change_hist[i] = '0;
    gain_total = 0;
    loss_total = 0;
    next_slot  = 0;
    bars_held  = 0;
  endfunction

  // Advance the predicted window by one bar and return the index it should produce.
  function automatic rsi_result_t index_of_bar(input logic [rsi_pkg::PRICE_W-1:0] op,
                                               input logic [rsi_pkg::PRICE_W-1:0] cp,
                                               input logic rs);
    logic [63:0]                 diff;
    logic [63:0]                 mag;
    bit                          neg;
    logic [rsi_pkg::ENTRY_W-1:0] entry;
    logic [rsi_pkg::ENTRY_W-1:0] old;
    int unsigned                 len;
    int unsigned                 slot;
    longint unsigned             total;
    rsi_result_t                 res;

    len = (window_reg < 1) ? 1 : window_reg;
    if (len > rsi_pkg::WINDOW_MAX_DEF) len = rsi_pkg::WINDOW_MAX_DEF;
    if (rs) clear_window_history();

    // Relative change as sign and truncated, saturated magnitude.
    res = '0;
    res.bad = (op == '0);
    entry = '0;
    if (op != '0) begin
      neg  = (cp < op);
      diff = neg ? 64'(op - cp) : 64'(cp - op);
      mag  = (diff << rsi_pkg::RATIO_FRAC_BITS_DEF) / 64'(op);
      if (mag > 64'(rsi_pkg::CHANGE_MAX)) mag = 64'(rsi_pkg::CHANGE_MAX);
      if (mag == 0) neg = 1'b0;
      entry = {neg, mag[rsi_pkg::CHANGE_W-1:0]};
    end

    // Replace the oldest entry once the window is full.
    slot = (next_slot >= len) ? 0 : next_slot;
    if (bars_held >= len) begin
      old = change_hist[slot];
      if (old[rsi_pkg::CHANGE_W]) loss_total -= old[rsi_pkg::CHANGE_W-1:0];
      else gain_total -= old[rsi_pkg::CHANGE_W-1:0];
    end else begin
      bars_held++;
    end
    change_hist[slot] = entry;
    if (entry[rsi_pkg::CHANGE_W]) loss_total += entry[rsi_pkg::CHANGE_W-1:0];
    else gain_total += entry[rsi_pkg::CHANGE_W-1:0];
    next_slot = (slot + 1 >= len) ? 0 : slot + 1;

    // Index with round-half-up once the window is full.
    res.rdy = (bars_held >= len);
    if (res.rdy) begin
      total = gain_total + loss_total;
      if (total == 0) res.undef = 1'b1;
      else res.rsi = rsi_pkg::RSI_W'((longint'(rsi_pkg::SCALE_Q78) * gain_total + total / 2)
                                     / total);
    end
    return res;
  endfunction

  task automatic report_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Watch every handshake; compare results first, then predict newly taken bars.
  always @(posedge clk) begin
    rsi_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (undefined) undef_seen++;
        if (bad_open) bad_seen++;
        if (index_expect_q.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual rsi %0d",
                   $time, rsi_value);
          errors++;
        end else begin
          want = index_expect_q.pop_front();
          report_field("rsi_value", want.rsi, rsi_value);
          report_field("ready_res", want.rdy, ready_res);
          report_field("undefined", want.undef, undefined);
          report_field("bad_open", want.bad, bad_open);
        end
      end
      if (cfg_valid && cfg_ready) begin
        window_reg = cfg_data;
        clear_window_history();
        window_writes++;
      end
      if (in_valid && !in_stall) begin
        bars_in++;
        want = index_of_bar(open_price, close_price, restart);
        index_expect_q.push_back(fix_en_cur ? fix_cur : want);
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall before each result, one long hold to back up the block.
  initial begin
    int n;
    int got;
    bit held;
    got  = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (got == 150 && !held) begin
        n    = LONG_HOLD;
        held = 1'b1;
      end else begin
        n = recv_burst ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got++;
      if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
    end
  end

  // Offer one bar after a random gap and hold it until taken.
  task automatic send_bar(input logic [rsi_pkg::PRICE_W-1:0] op,
                          input logic [rsi_pkg::PRICE_W-1:0] cp,
                          input logic rs, input logic fix_en, input rsi_result_t fix);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    open_price  <= op;
    close_price <= cp;
    restart     <= rs;
    fix_en_cur  <= fix_en;
    fix_cur     <= fix;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Write the window length once every pending result is back and the block has settled.
  // The first edge lets the monitor record a bar taken at the edge just passed.
  task automatic set_window(input logic [rsi_pkg::CFG_W-1:0] len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (index_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    logic [rsi_pkg::PRICE_W-1:0] op;
    logic [rsi_pkg::PRICE_W-1:0] cp;
    logic [rsi_pkg::PRICE_W-1:0] step;
    logic                        rs;
    int                          kind;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg_en) set_window(DIRECTED[i].cfg_val);
      send_bar(DIRECTED[i].op, DIRECTED[i].cp, DIRECTED[i].rs,
               DIRECTED[i].fix_en, DIRECTED[i].fix);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_window((PHASE_WIN[p] < 0) ? rsi_pkg::CFG_W'($urandom_range(1, rsi_pkg::WINDOW_MAX_DEF))
                                    : rsi_pkg::CFG_W'(PHASE_WIN[p]));
      for (int k = 0; k < PHASE_LEN[p]; k++) begin
        // Mostly plausible bars around the open, with flat, zero-open and wild ones mixed in.
        kind = $urandom_range(0, 19);
        op   = $urandom;
        cp   = $urandom;
        case (kind)
          0: op = '0;
          1, 2: cp = op;
          3, 4, 5: ;
          6: begin
            op = $urandom_range(1, 255);
            cp = $urandom_range(0, 511);
          end
          default: begin
            if (op == '0) op = 1;
            step = op >> $urandom_range(1, 14);
            if ($urandom_range(0, 1))
              cp = (op > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : op + step;
            else
              cp = op - step;
          end
        endcase
        rs = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_bar(op, cp, rs, 1'b0, NO_FIX);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (index_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d bars over %0d window writes; %0d results checked.",
             bars_in, window_writes, results_out);
    $display("Results seen: %0d with no movement in window, %0d with zero open price.",
             undef_seen, bad_seen);
    if (errors == 0 && index_expect_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
